### hw/rtl/afd_pkg.sv
package afd_pkg;

    // default time width in bits
    localparam int TIME_WIDTH_DEF = 64;

    // field widths
    localparam int ACC_W    = 19;
    localparam int SRC_W    = 3;
    localparam int ORIENT_W = 2;
    localparam int NORM_W   = 14;
    localparam int RATIO_W  = 16;
    localparam int CONF_W   = 16;
    localparam int STALE_W  = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_NORM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NORM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_RATIO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_RATIO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM     = 3'd5;

    // register reset values
    localparam logic [STALE_W-1:0]        RST_STALE_LIMIT = 32'd100000;
    localparam logic [NORM_W-1:0]         RST_MIN_NORM    = 14'd500;
    localparam logic [NORM_W-1:0]         RST_MAX_NORM    = 14'd1500;
    localparam logic signed [RATIO_W-1:0] RST_FLIP_RATIO  = -16'sd16384;
    localparam logic signed [RATIO_W-1:0] RST_UP_RATIO    = 16'sd16384;
    localparam logic [CONF_W-1:0]         RST_CONFIRM     = 16'd500;

    // orientation codes
    localparam logic [ORIENT_W-1:0] ORIENT_UNKNOWN = 2'd0;
    localparam logic [ORIENT_W-1:0] ORIENT_UPRIGHT = 2'd1;
    localparam logic [ORIENT_W-1:0] ORIENT_TILT    = 2'd2;
    localparam logic [ORIENT_W-1:0] ORIENT_FLIPPED = 2'd3;

    // g in units of 1/20000 m/s^2, and 20000^2 = K_ODD * 2^K_SHIFT
    localparam logic [17:0] G_NUM       = 18'd196133;
    localparam logic [18:0] K_ODD       = 19'd390625;
    localparam int          K_SHIFT     = 10;
    // Q1.15 scale squared
    localparam int          SHARE_SHIFT = 30;
    // ms to us
    localparam logic [9:0]  US_PER_MS   = 10'd1000;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration register file
    typedef struct packed {
        logic [STALE_W-1:0]        stale_limit_us;
        logic [NORM_W-1:0]         min_norm_milli_g;
        logic [NORM_W-1:0]         max_norm_milli_g;
        logic signed [RATIO_W-1:0] flipped_ratio;
        logic signed [RATIO_W-1:0] upright_ratio;
        logic [CONF_W-1:0]         confirm_ms;
    } t_cfg;

    // classification made at the front
    typedef struct packed {
        logic fresh;
        logic src_chg;
    } t_class;

endpackage

### hw/rtl/accel_flip_detector_unit.sv
// Accelerometer flip detector. Each accepted sample yields exactly one result
// (orientation with the source id and receive time echoed), in input order.
// The front checks freshness and tracks the source id in the accept cycle and
// places the sample in a four-entry queue; the back works one sample at a time
// through a three-step multiply sequence (squares, sum and squared length
// bounds, partial products) and then compares and updates the orientation
// state. The back takes the next queued sample, if there is one, in the
// cycle in which it commits the previous one. A result waits in an output
// register while the front keeps taking samples until the queue fills.
// Configuration writes take effect on the next clock edge and are to be made
// only while no sample is in flight. There is no clearing pass after reset.
module accel_flip_detector_unit #(
    parameter int TIME_WIDTH = afd_pkg::TIME_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [afd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [afd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [TIME_WIDTH-1:0]               i_now_time_us,
    input  logic [TIME_WIDTH-1:0]               i_sample_time_us,
    input  logic [afd_pkg::SRC_W-1:0]           i_sensor_source,
    input  logic                                i_sample_ok,
    input  logic signed [afd_pkg::ACC_W-1:0]    i_accel_x,
    input  logic signed [afd_pkg::ACC_W-1:0]    i_accel_y,
    input  logic signed [afd_pkg::ACC_W-1:0]    i_accel_z,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [afd_pkg::ORIENT_W-1:0]        o_orientation,
    output logic [afd_pkg::SRC_W-1:0]           o_echo_source,
    output logic [TIME_WIDTH-1:0]               o_echo_time_us
);

    localparam int ITEM_W = 2 * TIME_WIDTH + afd_pkg::SRC_W + 3 * afd_pkg::ACC_W
                            + $bits(afd_pkg::t_class);

    afd_pkg::t_cfg   r_cfg;
    afd_pkg::t_class w_class;
    afd_pkg::t_class w_q_class;
    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;
    logic [ITEM_W-1:0] w_q_in;
    logic [ITEM_W-1:0] w_q_out;

    logic [TIME_WIDTH-1:0]             w_q_now;
    logic [TIME_WIDTH-1:0]             w_q_st;
    logic [afd_pkg::SRC_W-1:0]         w_q_src;
    logic signed [afd_pkg::ACC_W-1:0]  w_q_x;
    logic signed [afd_pkg::ACC_W-1:0]  w_q_y;
    logic signed [afd_pkg::ACC_W-1:0]  w_q_z;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stale_limit_us   <= afd_pkg::RST_STALE_LIMIT;
            r_cfg.min_norm_milli_g <= afd_pkg::RST_MIN_NORM;
            r_cfg.max_norm_milli_g <= afd_pkg::RST_MAX_NORM;
            r_cfg.flipped_ratio    <= afd_pkg::RST_FLIP_RATIO;
            r_cfg.upright_ratio    <= afd_pkg::RST_UP_RATIO;
            r_cfg.confirm_ms       <= afd_pkg::RST_CONFIRM;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                afd_pkg::CFG_STALE_LIMIT:
                    r_cfg.stale_limit_us <= i_cfg_data[afd_pkg::STALE_W-1:0];
                afd_pkg::CFG_MIN_NORM:
                    r_cfg.min_norm_milli_g <= i_cfg_data[afd_pkg::NORM_W-1:0];
                afd_pkg::CFG_MAX_NORM:
                    r_cfg.max_norm_milli_g <= i_cfg_data[afd_pkg::NORM_W-1:0];
                afd_pkg::CFG_FLIP_RATIO:
                    r_cfg.flipped_ratio <= i_cfg_data[afd_pkg::RATIO_W-1:0];
                afd_pkg::CFG_UP_RATIO:
                    r_cfg.upright_ratio <= i_cfg_data[afd_pkg::RATIO_W-1:0];
                afd_pkg::CFG_CONFIRM:
                    r_cfg.confirm_ms <= i_cfg_data[afd_pkg::CONF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: accept and classify
    afd_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_now_time_us    (i_now_time_us),
        .i_sample_time_us (i_sample_time_us),
        .i_sensor_source  (i_sensor_source),
        .i_sample_ok      (i_sample_ok),
        .i_stale_limit_us (r_cfg.stale_limit_us),
        .i_q_full         (w_full),
        .o_q_push         (w_push),
        .o_class          (w_class)
    );

    // queue entry packing
    assign w_q_in = {i_now_time_us, i_sample_time_us, i_sensor_source,
                     i_accel_x, i_accel_y, i_accel_z, w_class};
    assign {w_q_now, w_q_st, w_q_src, w_q_x, w_q_y, w_q_z, w_q_class} = w_q_out;

    afd_fifo #(
        .DATA_WIDTH (ITEM_W),
        .DEPTH      (afd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // back: arithmetic, orientation state and result register
    afd_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_empty        (w_empty),
        .o_q_pop          (w_pop),
        .i_class          (w_q_class),
        .i_now_time_us    (w_q_now),
        .i_sample_time_us (w_q_st),
        .i_sensor_source  (w_q_src),
        .i_accel_x        (w_q_x),
        .i_accel_y        (w_q_y),
        .i_accel_z        (w_q_z),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_orientation    (o_orientation),
        .o_echo_source    (o_echo_source),
        .o_echo_time_us   (o_echo_time_us)
    );

endmodule

### hw/rtl/afd_front.sv
module afd_front #(
    parameter int TIME_WIDTH = afd_pkg::TIME_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [TIME_WIDTH-1:0]       i_now_time_us,
    input  logic [TIME_WIDTH-1:0]       i_sample_time_us,
    input  logic [afd_pkg::SRC_W-1:0]   i_sensor_source,
    input  logic                        i_sample_ok,
    input  logic [afd_pkg::STALE_W-1:0] i_stale_limit_us,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output afd_pkg::t_class             o_class
);

    logic [afd_pkg::SRC_W-1:0] r_last_source;
    logic [afd_pkg::SRC_W-1:0] n_last_source;
    logic [TIME_WIDTH-1:0]     w_age;
    logic                      w_fresh;

    // handshake into the queue
    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    // freshness: sample ok, received no later than now and not older than the limit
    assign w_age   = i_now_time_us - i_sample_time_us;
    assign w_fresh = i_sample_ok && (i_sample_time_us <= i_now_time_us)
                     && (w_age <= TIME_WIDTH'(i_stale_limit_us));

    assign o_class.fresh   = w_fresh;
    assign o_class.src_chg = w_fresh && (r_last_source != i_sensor_source);

    // source tracking, only fresh samples move it
    always_comb begin
        n_last_source = r_last_source;
        if (o_q_push && w_fresh) begin
            n_last_source = i_sensor_source;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_source <= '0;
        end else begin
            r_last_source <= n_last_source;
        end
    end

endmodule

### hw/rtl/afd_fifo.sv
module afd_fifo #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = afd_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DATA_WIDTH-1:0] i_data,
    input  logic                  i_pop,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]         r_wr;
    logic [AW-1:0]         n_wr;
    logic [AW-1:0]         r_rd;
    logic [AW-1:0]         n_rd;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        n_count = r_count + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### hw/rtl/afd_back.sv
module afd_back #(
    parameter int TIME_WIDTH = afd_pkg::TIME_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  afd_pkg::t_cfg                      i_cfg,
    // queue head
    input  logic                               i_q_empty,
    output logic                               o_q_pop,
    input  afd_pkg::t_class                    i_class,
    input  logic [TIME_WIDTH-1:0]              i_now_time_us,
    input  logic [TIME_WIDTH-1:0]              i_sample_time_us,
    input  logic [afd_pkg::SRC_W-1:0]          i_sensor_source,
    input  logic signed [afd_pkg::ACC_W-1:0]   i_accel_x,
    input  logic signed [afd_pkg::ACC_W-1:0]   i_accel_y,
    input  logic signed [afd_pkg::ACC_W-1:0]   i_accel_z,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [afd_pkg::ORIENT_W-1:0]       o_orientation,
    output logic [afd_pkg::SRC_W-1:0]          o_echo_source,
    output logic [TIME_WIDTH-1:0]              o_echo_time_us
);

    localparam int SQ_W   = 2 * afd_pkg::ACC_W - 1;
    localparam int SUM_W  = SQ_W + 1;
    localparam int HALF_W = SUM_W / 2;
    localparam int HI_W   = SUM_W - HALF_W;
    localparam int MG_W   = 32;
    localparam int R2_W   = 2 * afd_pkg::RATIO_W - 1;
    localparam int CUS_W  = 26;
    localparam int PK_W   = HI_W + 19;
    localparam int PR_W   = R2_W + HI_W;
    localparam int SK_W   = PK_W + HALF_W;
    localparam int CMP_W  = PR_W + HALF_W;
    localparam int NRM_W  = SK_W + afd_pkg::K_SHIFT;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SUM    = 2'd1;
    localparam logic [1:0] ST_MUL    = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    // z * 32768 <= r * sqrt(s), from signs and the compare of the squares
    function automatic logic share_le(input logic z_pos, input logic r_neg,
                                      input logic r_zero, input logic lt,
                                      input logic eq);
        logic res;
        if (!z_pos && !r_neg) begin
            res = 1'b1;
        end else if (z_pos && (r_neg || r_zero)) begin
            res = 1'b0;
        end else if (z_pos) begin
            res = lt || eq;
        end else begin
            res = !lt;
        end
        return res;
    endfunction

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_commit;
    logic       w_load;

    // item held while it is worked on
    logic                      r_fresh;
    logic                      r_chg;
    logic [TIME_WIDTH-1:0]     r_now;
    logic [TIME_WIDTH-1:0]     r_st;
    logic [afd_pkg::SRC_W-1:0] r_src;
    logic                      r_z_pos;
    logic                      r_z_neg;

    // step one: squares and scaled bounds
    logic [afd_pkg::ACC_W-1:0] w_ax;
    logic [afd_pkg::ACC_W-1:0] w_ay;
    logic [afd_pkg::ACC_W-1:0] w_az;
    logic [SQ_W:0]             w_x2;
    logic [SQ_W:0]             w_y2;
    logic [SQ_W:0]             w_z2;
    logic [afd_pkg::RATIO_W-1:0] w_afr;
    logic [afd_pkg::RATIO_W-1:0] w_aur;
    logic [2*afd_pkg::RATIO_W-1:0] w_af2;
    logic [2*afd_pkg::RATIO_W-1:0] w_au2;
    logic [SQ_W-1:0]  r_x2;
    logic [SQ_W-1:0]  r_y2;
    logic [SQ_W-1:0]  r_z2;
    logic [MG_W-1:0]  r_min_g;
    logic [MG_W-1:0]  r_max_g;
    logic [R2_W-1:0]  r_af2;
    logic [R2_W-1:0]  r_au2;
    logic [CUS_W-1:0] r_conf_us;

    // step two: sum of squares and squared bounds
    logic [SUM_W-1:0] r_s;
    logic [63:0]      w_tmin;
    logic [63:0]      w_tmax;
    logic [63:0]      r_tmin;
    logic [63:0]      r_tmax;

    // step three: partial products and timer checks
    logic [HALF_W-1:0]     w_slo;
    logic [HI_W-1:0]       w_shi;
    logic [PK_W-1:0]       r_pk_lo;
    logic [PK_W-1:0]       r_pk_hi;
    logic [PR_W-1:0]       r_pf_lo;
    logic [PR_W-1:0]       r_pf_hi;
    logic [PR_W-1:0]       r_pu_lo;
    logic [PR_W-1:0]       r_pu_hi;
    logic                  r_s_nz;
    logic [TIME_WIDTH-1:0] w_f_eff;
    logic [TIME_WIDTH-1:0] w_u_eff;
    logic [TIME_WIDTH-1:0] w_f_base;
    logic [TIME_WIDTH-1:0] w_u_base;
    logic [TIME_WIDTH-1:0] w_f_diff;
    logic [TIME_WIDTH-1:0] w_u_diff;
    logic [TIME_WIDTH-1:0] r_f_base;
    logic [TIME_WIDTH-1:0] r_u_base;
    logic                  r_f_ge;
    logic                  r_u_ge;

    // step four: compares and state update
    logic [SK_W-1:0]  w_sk_odd;
    logic [NRM_W:0]   w_sk;
    logic             w_norm_bad;
    logic [CMP_W-1:0] w_lhs;
    logic [CMP_W-1:0] w_rhs_f;
    logic [CMP_W-1:0] w_rhs_u;
    logic             w_flip;
    logic             w_up;
    logic [afd_pkg::ORIENT_W-1:0] w_stable_eff;

    // orientation state
    logic [afd_pkg::ORIENT_W-1:0] r_stable;
    logic [afd_pkg::ORIENT_W-1:0] n_stable;
    logic [TIME_WIDTH-1:0]        r_fstart;
    logic [TIME_WIDTH-1:0]        n_fstart;
    logic [TIME_WIDTH-1:0]        r_ustart;
    logic [TIME_WIDTH-1:0]        n_ustart;

    // result register
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [afd_pkg::ORIENT_W-1:0] r_orient;
    logic [afd_pkg::SRC_W-1:0]    r_echo_src;
    logic [TIME_WIDTH-1:0]        r_echo_time;

    // sequencer
    assign w_commit = (r_state == ST_COMMIT) && (!r_out_valid || i_out_ready);
    assign w_load   = ((r_state == ST_IDLE) || w_commit) && !i_q_empty;
    assign o_q_pop  = w_load;

    always_comb begin
        case (r_state)
            ST_IDLE:   n_state = w_load ? ST_SUM : ST_IDLE;
            ST_SUM:    n_state = ST_MUL;
            ST_MUL:    n_state = ST_COMMIT;
            ST_COMMIT: n_state = w_commit ? (w_load ? ST_SUM : ST_IDLE) : ST_COMMIT;
            default:   n_state = ST_IDLE;
        endcase
    end

    // magnitudes for the squares
    assign w_ax  = i_accel_x[afd_pkg::ACC_W-1] ? (~i_accel_x + 1'b1) : i_accel_x;
    assign w_ay  = i_accel_y[afd_pkg::ACC_W-1] ? (~i_accel_y + 1'b1) : i_accel_y;
    assign w_az  = i_accel_z[afd_pkg::ACC_W-1] ? (~i_accel_z + 1'b1) : i_accel_z;
    assign w_x2  = w_ax * w_ax;
    assign w_y2  = w_ay * w_ay;
    assign w_z2  = w_az * w_az;
    assign w_afr = i_cfg.flipped_ratio[afd_pkg::RATIO_W-1]
                   ? (~i_cfg.flipped_ratio + 1'b1) : i_cfg.flipped_ratio;
    assign w_aur = i_cfg.upright_ratio[afd_pkg::RATIO_W-1]
                   ? (~i_cfg.upright_ratio + 1'b1) : i_cfg.upright_ratio;
    assign w_af2 = w_afr * w_afr;
    assign w_au2 = w_aur * w_aur;

    // load the item and form the squares
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_fresh   <= i_class.fresh;
            r_chg     <= i_class.src_chg;
            r_now     <= i_now_time_us;
            r_st      <= i_sample_time_us;
            r_src     <= i_sensor_source;
            r_z_pos   <= !i_accel_z[afd_pkg::ACC_W-1] && (i_accel_z != '0);
            r_z_neg   <= i_accel_z[afd_pkg::ACC_W-1];
            r_x2      <= w_x2[SQ_W-1:0];
            r_y2      <= w_y2[SQ_W-1:0];
            r_z2      <= w_z2[SQ_W-1:0];
            r_min_g   <= MG_W'(i_cfg.min_norm_milli_g) * MG_W'(afd_pkg::G_NUM);
            r_max_g   <= MG_W'(i_cfg.max_norm_milli_g) * MG_W'(afd_pkg::G_NUM);
            r_af2     <= w_af2[R2_W-1:0];
            r_au2     <= w_au2[R2_W-1:0];
            r_conf_us <= CUS_W'(i_cfg.confirm_ms) * CUS_W'(afd_pkg::US_PER_MS);
        end
    end

    // sum of squares and squared bounds
    assign w_tmin = r_min_g * r_min_g;
    assign w_tmax = r_max_g * r_max_g;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SUM) begin
            r_s    <= SUM_W'(r_x2) + SUM_W'(r_y2) + SUM_W'(r_z2);
            r_tmin <= w_tmin;
            r_tmax <= w_tmax;
        end
    end

    // split the sum for the products
    assign w_slo = r_s[HALF_W-1:0];
    assign w_shi = r_s[SUM_W-1:HALF_W];

    // timers after a possible source change
    assign w_f_eff  = r_chg ? '0 : r_fstart;
    assign w_u_eff  = r_chg ? '0 : r_ustart;
    assign w_f_base = (w_f_eff == '0) ? r_now : w_f_eff;
    assign w_u_base = (w_u_eff == '0) ? r_now : w_u_eff;
    assign w_f_diff = r_now - w_f_base;
    assign w_u_diff = r_now - w_u_base;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_pk_lo  <= PK_W'(w_slo) * PK_W'(afd_pkg::K_ODD);
            r_pk_hi  <= PK_W'(w_shi) * PK_W'(afd_pkg::K_ODD);
            r_pf_lo  <= PR_W'(r_af2) * PR_W'(w_slo);
            r_pf_hi  <= PR_W'(r_af2) * PR_W'(w_shi);
            r_pu_lo  <= PR_W'(r_au2) * PR_W'(w_slo);
            r_pu_hi  <= PR_W'(r_au2) * PR_W'(w_shi);
            r_s_nz   <= (r_s != '0);
            r_f_base <= w_f_base;
            r_u_base <= w_u_base;
            r_f_ge   <= (w_f_diff >= TIME_WIDTH'(r_conf_us));
            r_u_ge   <= (w_u_diff >= TIME_WIDTH'(r_conf_us));
        end
    end

    // length bounds: s * 20000^2 against the squared bounds
    assign w_sk_odd   = {r_pk_hi, HALF_W'(0)} + SK_W'(r_pk_lo);
    assign w_sk       = {1'b0, w_sk_odd, afd_pkg::K_SHIFT'(0)};
    assign w_norm_bad = ((r_tmin != '0) && (w_sk < (NRM_W+1)'(r_tmin)))
                        || (w_sk > (NRM_W+1)'(r_tmax));

    // z share compares: z^2 * 2^30 against r^2 * s
    assign w_lhs   = CMP_W'({r_z2, afd_pkg::SHARE_SHIFT'(0)});
    assign w_rhs_f = {r_pf_hi, HALF_W'(0)} + CMP_W'(r_pf_lo);
    assign w_rhs_u = {r_pu_hi, HALF_W'(0)} + CMP_W'(r_pu_lo);

    assign w_flip = share_le(r_z_pos,
                             i_cfg.flipped_ratio[afd_pkg::RATIO_W-1],
                             i_cfg.flipped_ratio == '0,
                             w_lhs < w_rhs_f, w_lhs == w_rhs_f);
    assign w_up   = share_le(r_z_neg,
                             !i_cfg.upright_ratio[afd_pkg::RATIO_W-1]
                             && (i_cfg.upright_ratio != '0),
                             i_cfg.upright_ratio == '0,
                             w_lhs < w_rhs_u, w_lhs == w_rhs_u);

    assign w_stable_eff = r_chg ? afd_pkg::ORIENT_UNKNOWN : r_stable;

    // orientation state update
    always_comb begin
        n_stable = r_stable;
        n_fstart = r_fstart;
        n_ustart = r_ustart;
        if (w_commit) begin
            if (!r_fresh || w_norm_bad) begin
                n_stable = afd_pkg::ORIENT_UNKNOWN;
                n_fstart = '0;
                n_ustart = '0;
            end else if (r_s_nz && w_flip) begin
                n_ustart = '0;
                n_fstart = r_f_base;
                if (r_f_ge) begin
                    n_stable = afd_pkg::ORIENT_FLIPPED;
                end else if (w_stable_eff != afd_pkg::ORIENT_FLIPPED) begin
                    n_stable = afd_pkg::ORIENT_TILT;
                end else begin
                    n_stable = afd_pkg::ORIENT_FLIPPED;
                end
            end else if (r_s_nz && w_up) begin
                n_fstart = '0;
                n_ustart = r_u_base;
                n_stable = r_u_ge ? afd_pkg::ORIENT_UPRIGHT : w_stable_eff;
            end else begin
                n_stable = afd_pkg::ORIENT_TILT;
                n_fstart = '0;
                n_ustart = '0;
            end
        end
    end

    // result register handshake
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_stable    <= afd_pkg::ORIENT_UNKNOWN;
            r_fstart    <= '0;
            r_ustart    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_stable    <= n_stable;
            r_fstart    <= n_fstart;
            r_ustart    <= n_ustart;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_orient    <= n_stable;
            r_echo_src  <= r_src;
            r_echo_time <= r_st;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_orientation  = r_orient;
    assign o_echo_source  = r_echo_src;
    assign o_echo_time_us = r_echo_time;

endmodule

### tb/afd_orientation_checker.sv
`timescale 1ns / 1ps

// watches both channels of the flip detector, predicts every orientation
// and compares each result transaction against the oldest prediction
module afd_orientation_checker
    import afd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration writes
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    // sample channel
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [63:0]                 i_now_time_us,
    input  logic [63:0]                 i_sample_time_us,
    input  logic [SRC_W-1:0]            i_sensor_source,
    input  logic                        i_sample_ok,
    input  logic signed [ACC_W-1:0]     i_accel_x,
    input  logic signed [ACC_W-1:0]     i_accel_y,
    input  logic signed [ACC_W-1:0]     i_accel_z,
    // result channel
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [ORIENT_W-1:0]         i_orientation,
    input  logic [SRC_W-1:0]            i_echo_source,
    input  logic [63:0]                 i_echo_time_us,
    // status for the test top
    output int                          o_mismatches,
    output int                          o_pending
);

    // 20000^2, the milli-g scale squared
    localparam logic [127:0] LEN_SCALE = 128'd400000000;

    typedef struct packed {
        logic [ORIENT_W-1:0] orientation;
        logic [SRC_W-1:0]    source;
        logic [63:0]         stamp_us;
    } orient_result_t;

    orient_result_t pending_orientations[$];
    int             miss_count = 0;

    // shadow copy of the register file
    logic [STALE_W-1:0]        stale_limit;
    logic [NORM_W-1:0]         min_norm;
    logic [NORM_W-1:0]         max_norm;
    logic signed [RATIO_W-1:0] flip_ratio;
    logic signed [RATIO_W-1:0] up_ratio;
    logic [CONF_W-1:0]         confirm_ms;

    // tracking state
    logic [SRC_W-1:0]    last_src;
    logic [ORIENT_W-1:0] held_orient;
    logic [63:0]         flip_since;
    logic [63:0]         up_since;

    function automatic void clear_track();
        held_orient = ORIENT_UNKNOWN;
        flip_since  = '0;
        up_since    = '0;
    endfunction

    // exact test of z * 32768 <= r * sqrt(s) for s > 0
    function automatic bit z_share_at_most(input longint z, input longint r,
                                           input logic [63:0] s);
        logic [63:0]  az;
        logic [63:0]  ar;
        logic [127:0] lhs;
        logic [127:0] rhs;
        az = (z < 0) ? -z : z;
        ar = (r < 0) ? -r : r;
        if (z <= 0 && r >= 0) return 1'b1;
        if (z > 0 && r <= 0) return 1'b0;
        lhs = {64'd0, az * az} << SHARE_SHIFT;
        rhs = {64'd0, ar * ar} * {64'd0, s};
        return (z > 0) ? (lhs <= rhs) : (lhs >= rhs);
    endfunction

    // advances the tracking state by one sample and returns its result
    function automatic orient_result_t predict_orientation(
        input logic [63:0]             now_us,
        input logic [63:0]             stamp_us,
        input logic [SRC_W-1:0]        src,
        input logic                    ok,
        input logic signed [ACC_W-1:0] ax,
        input logic signed [ACC_W-1:0] ay,
        input logic signed [ACC_W-1:0] az
    );
        longint         x;
        longint         y;
        longint         z;
        longint         r_flip;
        longint         r_up;
        logic [63:0]    sum_sq;
        logic [63:0]    min_len;
        logic [63:0]    max_len;
        logic [63:0]    conf_us;
        logic [127:0]   scaled;
        orient_result_t res;
        x        = ax;
        y        = ay;
        z        = az;
        r_flip   = flip_ratio;
        r_up     = up_ratio;
        res.source   = src;
        res.stamp_us = stamp_us;
        if (!ok || stamp_us > now_us || (now_us - stamp_us) > {32'd0, stale_limit}) begin
            clear_track();
        end else begin
            if (last_src != src) begin
                last_src = src;
                clear_track();
            end
            sum_sq  = x * x + y * y + z * z;
            min_len = min_norm * G_NUM;
            max_len = max_norm * G_NUM;
            scaled  = {64'd0, sum_sq} * LEN_SCALE;
            if ((min_len != 0 && scaled < {64'd0, min_len * min_len}) ||
                scaled > {64'd0, max_len * max_len}) begin
                clear_track();
            end else begin
                conf_us = confirm_ms * 64'd1000;
                if (sum_sq != 0 && z_share_at_most(z, r_flip, sum_sq)) begin
                    up_since = '0;
                    if (flip_since == 0) flip_since = now_us;
                    if ((now_us - flip_since) >= conf_us)
                        held_orient = ORIENT_FLIPPED;
                    else if (held_orient != ORIENT_FLIPPED)
                        held_orient = ORIENT_TILT;
                end else if (sum_sq != 0 && z_share_at_most(-z, -r_up, sum_sq)) begin
                    flip_since = '0;
                    if (up_since == 0) up_since = now_us;
                    if ((now_us - up_since) >= conf_us)
                        held_orient = ORIENT_UPRIGHT;
                end else begin
                    flip_since  = '0;
                    up_since    = '0;
                    held_orient = ORIENT_TILT;
                end
            end
        end
        res.orientation = held_orient;
        return res;
    endfunction

    // predict on sample transactions, compare on result transactions
    always @(posedge i_clk) begin
        orient_result_t want;
        if (!i_rst_n) begin
            stale_limit = RST_STALE_LIMIT;
            min_norm    = RST_MIN_NORM;
            max_norm    = RST_MAX_NORM;
            flip_ratio  = RST_FLIP_RATIO;
            up_ratio    = RST_UP_RATIO;
            confirm_ms  = RST_CONFIRM;
            last_src    = '0;
            clear_track();
            pending_orientations.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STALE_LIMIT: stale_limit = i_cfg_data[STALE_W-1:0];
                    CFG_MIN_NORM:    min_norm    = i_cfg_data[NORM_W-1:0];
                    CFG_MAX_NORM:    max_norm    = i_cfg_data[NORM_W-1:0];
                    CFG_FLIP_RATIO:  flip_ratio  = i_cfg_data[RATIO_W-1:0];
                    CFG_UP_RATIO:    up_ratio    = i_cfg_data[RATIO_W-1:0];
                    CFG_CONFIRM:     confirm_ms  = i_cfg_data[CONF_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                pending_orientations.push_back(predict_orientation(
                    i_now_time_us, i_sample_time_us, i_sensor_source, i_sample_ok,
                    i_accel_x, i_accel_y, i_accel_z));
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_orientations.size() == 0) begin
                    if (miss_count < 10)
                        $display("%0t: unexpected result orient %0d src %0d time %h",
                                 $realtime, i_orientation, i_echo_source, i_echo_time_us);
                    miss_count++;
                end else begin
                    want = pending_orientations.pop_front();
                    if (want.orientation != i_orientation || want.source != i_echo_source ||
                        want.stamp_us != i_echo_time_us) begin
                        if (miss_count < 10)
                            $display("%0t: result mismatch, expected %0d/%0d/%h got %0d/%0d/%h",
                                     $realtime, want.orientation, want.source, want.stamp_us,
                                     i_orientation, i_echo_source, i_echo_time_us);
                        miss_count++;
                    end
                end
            end
        end
        o_pending    <= pending_orientations.size();
        o_mismatches <= miss_count;
    end

endmodule

### tb/accel_flip_detector_unit_test.sv
`timescale 1ns / 1ps

module accel_flip_detector_unit_test;

    import afd_pkg::*;

    // about one g in milli-m/s^2
    localparam int ONE_G = 9807;

    typedef struct packed {
        logic [63:0]             now_us;
        logic [63:0]             stamp_us;
        logic [SRC_W-1:0]        src;
        logic                    ok;
        logic signed [ACC_W-1:0] ax;
        logic signed [ACC_W-1:0] ay;
        logic signed [ACC_W-1:0] az;
    } accel_sample_t;

    typedef enum int {
        POSE_UPRIGHT,
        POSE_FLIPPED,
        POSE_SWEEP,
        POSE_ZERO,
        POSE_NOISE
    } pose_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [63:0]             now_time_us = '0;
    logic [63:0]             sample_time_us = '0;
    logic [SRC_W-1:0]        sensor_source = '0;
    logic                    sample_ok = 1'b0;
    logic signed [ACC_W-1:0] accel_x = '0;
    logic signed [ACC_W-1:0] accel_y = '0;
    logic signed [ACC_W-1:0] accel_z = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [ORIENT_W-1:0]     orientation;
    logic [SRC_W-1:0]        echo_source;
    logic [63:0]             echo_time_us;
    int                      mismatches;
    int                      pending;

    // stimulus state
    logic [63:0]      clock_us;
    logic [SRC_W-1:0] cur_src;
    pose_t            cur_pose;
    int               burst_left;
    logic [31:0]      set_stale;
    logic [15:0]      set_confirm;

    accel_flip_detector_unit uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_now_time_us    (now_time_us),
        .i_sample_time_us (sample_time_us),
        .i_sensor_source  (sensor_source),
        .i_sample_ok      (sample_ok),
        .i_accel_x        (accel_x),
        .i_accel_y        (accel_y),
        .i_accel_z        (accel_z),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_orientation    (orientation),
        .o_echo_source    (echo_source),
        .o_echo_time_us   (echo_time_us)
    );

    afd_orientation_checker u_orient_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_now_time_us    (now_time_us),
        .i_sample_time_us (sample_time_us),
        .i_sensor_source  (sensor_source),
        .i_sample_ok      (sample_ok),
        .i_accel_x        (accel_x),
        .i_accel_y        (accel_y),
        .i_accel_z        (accel_z),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_orientation    (orientation),
        .i_echo_source    (echo_source),
        .i_echo_time_us   (echo_time_us),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic pose_t choose_pose();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return POSE_UPRIGHT;
        if (r < 60) return POSE_FLIPPED;
        if (r < 85) return POSE_SWEEP;
        if (r < 91) return POSE_ZERO;
        return POSE_NOISE;
    endfunction

    // present one sample and hold it until the transaction completes
    task automatic drive_sample(input accel_sample_t s);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = idle_cycles();
            if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        now_time_us    <= s.now_us;
        sample_time_us <= s.stamp_us;
        sensor_source  <= s.src;
        sample_ok      <= s.ok;
        accel_x        <= s.ax;
        accel_y        <= s.ay;
        accel_z        <= s.az;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_fixed(input logic [63:0] now_us, input logic [63:0] stamp_us,
                              input logic [SRC_W-1:0] src, input logic ok,
                              input int x, input int y, input int z);
        accel_sample_t s;
        s.now_us   = now_us;
        s.stamp_us = stamp_us;
        s.src      = src;
        s.ok       = ok;
        s.ax       = x;
        s.ay       = y;
        s.az       = z;
        drive_sample(s);
    endtask

    // a mostly well-formed sample stream with some stale, broken and noisy items
    task automatic make_random_sample(output accel_sample_t s);
        int unsigned step_max;
        int          mag;
        int          r;
        logic [63:0] age;
        if ($urandom_range(0, 99) < 5) begin
            s.now_us   = {$urandom, $urandom};
            s.stamp_us = {$urandom, $urandom};
            s.src      = $urandom;
            s.ok       = $urandom;
            s.ax       = $urandom;
            s.ay       = $urandom;
            s.az       = $urandom;
        end else begin
            step_max = set_confirm * 1000 / 3 + 2000;
            clock_us = clock_us + $urandom_range(0, step_max);
            if ($urandom_range(0, 24) == 0) cur_src = $urandom_range(0, 7);
            if ($urandom_range(0, 99) < 15) cur_pose = choose_pose();
            s.now_us = clock_us;
            s.src    = cur_src;
            s.ok     = ($urandom_range(0, 49) != 0);
            r = $urandom_range(0, 99);
            if (r < 90) begin
                age = $urandom_range(0, (set_stale < 50000) ? set_stale : 50000);
                s.stamp_us = clock_us - age;
            end else if (r < 94) begin
                age = {32'd0, set_stale} + 64'd1 + $urandom_range(0, 1000);
                s.stamp_us = clock_us - age;
            end else if (r < 97) begin
                s.stamp_us = clock_us - {32'd0, set_stale};
            end else begin
                s.stamp_us = clock_us + 64'd1 + $urandom_range(0, 1000);
            end
            if ($urandom_range(0, 9) == 0) mag = $urandom_range(0, 20000);
            else mag = $urandom_range(7000, 12500);
            case (cur_pose)
                POSE_UPRIGHT, POSE_FLIPPED: begin
                    s.ax = int'($urandom_range(0, mag / 2)) - mag / 4;
                    s.ay = int'($urandom_range(0, mag / 2)) - mag / 4;
                    s.az = (cur_pose == POSE_UPRIGHT) ? mag : -mag;
                end
                POSE_SWEEP: begin
                    s.ax = mag;
                    s.ay = int'($urandom_range(0, mag / 4)) - mag / 8;
                    s.az = int'($urandom_range(0, 2 * mag)) - mag;
                end
                POSE_ZERO: begin
                    s.ax = '0;
                    s.ay = '0;
                    s.az = '0;
                end
                default: begin
                    s.ax = $urandom;
                    s.ay = $urandom;
                    s.az = $urandom;
                end
            endcase
        end
    endtask

    task automatic run_random(input int count);
        accel_sample_t s;
        repeat (count) begin
            make_random_sample(s);
            drive_sample(s);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [31:0] stale, input logic [13:0] min_g,
                                 input logic [13:0] max_g, input logic [15:0] flip_r,
                                 input logic [15:0] up_r, input logic [15:0] conf);
        write_reg(CFG_STALE_LIMIT, stale);
        write_reg(CFG_MIN_NORM, {18'd0, min_g});
        write_reg(CFG_MAX_NORM, {18'd0, max_g});
        write_reg(CFG_FLIP_RATIO, {16'd0, flip_r});
        write_reg(CFG_UP_RATIO, {16'd0, up_r});
        write_reg(CFG_CONFIRM, {16'd0, conf});
        cfg_we      <= 1'b0;
        set_stale   = stale;
        set_confirm = conf;
    endtask

    // result side backpressure, with stretches of no stalls
    initial begin
        int n;
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 99) < 15) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end else begin
                n = idle_cycles();
                if (n > 0) begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // main sequence
    initial begin
        set_stale   = RST_STALE_LIMIT;
        set_confirm = RST_CONFIRM;
        clock_us    = '0;
        cur_src     = 3'd1;
        cur_pose    = POSE_UPRIGHT;
        burst_left  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed samples at the reset settings
        send_fixed(64'd0, 64'd0, 3'd1, 1'b1, 0, 0, ONE_G);            // start at time zero, held as no timer
        send_fixed(64'd1000, 64'd1000, 3'd1, 1'b1, 0, 0, ONE_G);
        send_fixed(64'd501000, 64'd500000, 3'd1, 1'b1, 0, 0, ONE_G);  // upright confirmed
        send_fixed(64'd600000, 64'd600000, 3'd1, 1'b0, 0, 0, ONE_G);  // not ok
        send_fixed(64'd700000, 64'd599999, 3'd1, 1'b1, 0, 0, ONE_G);  // one past stale
        send_fixed(64'd800000, 64'd700000, 3'd1, 1'b1, 0, 0, ONE_G);  // age exactly at limit
        send_fixed(64'd800001, 64'd800002, 3'd1, 1'b1, 0, 0, ONE_G);  // stamped in the future
        send_fixed(64'd900000, 64'd900000, 3'd2, 1'b1, 0, 0, ONE_G);  // source change
        send_fixed(64'd1000000, 64'd1000000, 3'd2, 1'b1, 0, 0, -ONE_G);
        send_fixed(64'd1499999, 64'd1499999, 3'd2, 1'b1, 0, 0, -ONE_G);
        send_fixed(64'd1500000, 64'd1500000, 3'd2, 1'b1, 0, 0, -ONE_G); // flipped confirmed
        send_fixed(64'd1550000, 64'd1550000, 3'd2, 1'b1, 0, ONE_G, 0);  // high tilt
        send_fixed(64'd1600000, 64'd1600000, 3'd2, 1'b1, 0, 0, 0);      // zero vector below min
        send_fixed(64'd1700000, 64'd1700000, 3'd7, 1'b1, -262144, -262144, -262144);
        send_fixed(64'd1700001, 64'd1700001, 3'd7, 1'b1, 262143, 262143, 262143);
        send_fixed(64'd1800000, 64'd1800000, 3'd7, 1'b1, 4903, 0, 0);   // just below min length
        send_fixed(64'd1800001, 64'd1800001, 3'd7, 1'b1, 4904, 0, 0);
        send_fixed(64'd1800002, 64'd1800002, 3'd7, 1'b1, 14709, 0, 0);
        send_fixed(64'd1800003, 64'd1800003, 3'd7, 1'b1, 14710, 0, 0);  // just above max length
        send_fixed(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 1'b1, 0, 0, ONE_G);
        send_fixed(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 3'd7, 1'b1, 0, 0, ONE_G);
        send_fixed(64'd2000000, 64'd2000000, 3'd0, 1'b1, 0, 0, -ONE_G); // source zero
        clock_us = 64'd2000000;
        run_random(110);
        settle();

        // widest bounds, extreme ratios, immediate confirm
        load_settings(32'hFFFF_FFFF, 14'd0, 14'd16000, 16'h8000, 16'h7FFF, 16'd0);
        clock_us = {$urandom, $urandom};
        run_random(110);
        settle();

        // only zero-age samples fresh, inverted bounds, longest confirm, wrapping clock
        load_settings(32'd0, 14'd16000, 14'd0, 16'h7FFF, 16'h8000, 16'hFFFF);
        clock_us = 64'hFFFF_FFFF_F000_0000;
        run_random(110);
        settle();

        // narrow bounds, zero thresholds, 1 ms confirm
        load_settings(32'd50000, 14'd800, 14'd1200, 16'h0000, 16'h0000, 16'd1);
        clock_us = {32'd0, $urandom};
        run_random(110);
        settle();

        // back to the reset values
        load_settings(RST_STALE_LIMIT, RST_MIN_NORM, RST_MAX_NORM,
                      RST_FLIP_RATIO, RST_UP_RATIO, RST_CONFIRM);
        clock_us = {$urandom, $urandom};
        run_random(110);
        settle();

        // random settings
        load_settings($urandom_range(1000, 300000), $urandom_range(0, 900),
                      $urandom_range(1000, 16000), -$urandom_range(0, 32768),
                      $urandom_range(0, 32767), $urandom_range(0, 2000));
        clock_us = {$urandom, $urandom};
        run_random(110);
        settle();

        // crossed thresholds
        load_settings(32'd200000, 14'd0, 14'd2000, 16'd16384, -16'sd16384, 16'd200);
        clock_us = {$urandom, $urandom};
        run_random(110);
        settle();

        if (mismatches == 0 && pending == 0) begin
            $display("accel_flip_detector_unit_test passed");
        end else begin
            $display("accel_flip_detector_unit_test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("accel_flip_detector_unit_test failed");
        $finish;
    end

endmodule
